// ===== rtl/lprp_pkg.sv =====
// ============================================================================
// lprp_pkg: shared types and codes for the length-prefixed request parser
// Holds the parse phase enum, the byte kind and status codes, and the
// request and result structs passed between the parser modules.
// ============================================================================
package lprp_pkg;

    typedef enum logic [2:0] {
        PH_VERSION = 3'd0,
        PH_COUNT   = 3'd1,
        PH_ARGLEN  = 3'd2,
        PH_ARGDATA = 3'd3,
        PH_DIRLEN  = 3'd4,
        PH_DIRDATA = 3'd5,
        PH_TAIL    = 3'd6
    } t_phase;

    // Byte kind and completed string kind codes.
    localparam logic [1:0] KIND_NONE = 2'd0;
    localparam logic [1:0] KIND_ARG  = 2'd1;
    localparam logic [1:0] KIND_DIR  = 2'd2;

    // Parse status codes.
    localparam logic [2:0] ST_OK            = 3'd0;
    localparam logic [2:0] ST_MISSING_VER   = 3'd1;
    localparam logic [2:0] ST_BAD_VER       = 3'd2;
    localparam logic [2:0] ST_MISSING_COUNT = 3'd3;
    localparam logic [2:0] ST_TRUNC_ARG     = 3'd4;
    localparam logic [2:0] ST_TRUNC_DIR     = 3'd5;
    localparam logic [2:0] ST_TRAILING      = 3'd6;

    // Version the register holds after reset.
    localparam logic [7:0] OPEN_VERSION = 8'd1;

    typedef struct packed {
        logic       has_byte;
        logic [7:0] data_byte;
        logic       end_of_payload;
    } t_req;

    typedef struct packed {
        logic [7:0]  byte_out;
        logic [1:0]  byte_kind;
        logic [31:0] arg_number;
        logic        string_complete;
        logic [1:0]  complete_kind;
        logic        parse_done;
        logic [2:0]  parse_status;
        logic [31:0] arg_total;
    } t_res;

endpackage

// ===== rtl/lprp_parse.sv =====
// ============================================================================
// lprp_parse: parse state and per-request step logic
// Holds the phase, prefix accumulator, counters and latched error, and
// computes the result of one request combinationally from the held request.
// ============================================================================
module lprp_parse #(
    parameter int LENGTH_BITS = 32
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_fire,
    input  lprp_pkg::t_req     i_req,
    input  logic [7:0]         i_exp_ver,
    output lprp_pkg::t_res     o_res
);

    localparam int PREFIX_BYTES = (LENGTH_BITS + 7) / 8;
    // Byte count (mod 4) at which a prefix is complete.
    localparam logic [1:0] PFX_END = 2'(PREFIX_BYTES % 4);

    lprp_pkg::t_phase       r_phase, n_phase;
    logic [1:0]             r_wbc, n_wbc;
    logic [LENGTH_BITS-1:0] r_word, n_word;
    logic [LENGTH_BITS-1:0] r_left, n_left;
    logic [LENGTH_BITS-1:0] r_argc, n_argc;
    logic [LENGTH_BITS-1:0] r_total, n_total;
    logic [LENGTH_BITS-1:0] r_content, n_content;
    logic [2:0]             r_err, n_err;

    logic [1:0]             wbc_inc;
    logic                   pfx_done;
    logic [LENGTH_BITS-1:0] word_val;

    assign wbc_inc  = r_wbc + 2'd1;
    assign pfx_done = (wbc_inc == PFX_END);
    assign word_val = LENGTH_BITS'({r_word, i_req.data_byte});

    always_comb begin
        lprp_pkg::t_phase ph_after;
        logic [LENGTH_BITS-1:0] num;
        logic [1:0]  kind;
        logic        done_str;
        logic [1:0]  ckind;
        logic [2:0]  status;

        n_phase   = r_phase;
        n_wbc     = r_wbc;
        n_word    = r_word;
        n_left    = r_left;
        n_argc    = r_argc;
        n_total   = r_total;
        n_content = r_content;
        n_err     = r_err;
        num       = r_argc;
        kind      = lprp_pkg::KIND_NONE;
        done_str  = 1'b0;
        ckind     = lprp_pkg::KIND_NONE;

        if (i_req.has_byte && r_err == lprp_pkg::ST_OK) begin
            unique case (r_phase)
                lprp_pkg::PH_VERSION: begin
                    if (i_req.data_byte != i_exp_ver) begin
                        n_err = lprp_pkg::ST_BAD_VER;
                    end else begin
                        n_phase = lprp_pkg::PH_COUNT;
                        n_wbc   = 2'd0;
                        n_word  = '0;
                    end
                end
                lprp_pkg::PH_COUNT, lprp_pkg::PH_ARGLEN, lprp_pkg::PH_DIRLEN: begin
                    n_wbc  = pfx_done ? 2'd0 : wbc_inc;
                    n_word = pfx_done ? '0 : word_val;
                    if (pfx_done) begin
                        if (r_phase == lprp_pkg::PH_COUNT) begin
                            n_total = word_val;
                            n_left  = word_val;
                            n_argc  = '0;
                            num     = '0;
                            n_phase = (word_val != '0) ? lprp_pkg::PH_ARGLEN
                                                       : lprp_pkg::PH_DIRLEN;
                        end else begin
                            n_content = word_val;
                            if (word_val != '0) begin
                                n_phase = (r_phase == lprp_pkg::PH_ARGLEN)
                                          ? lprp_pkg::PH_ARGDATA : lprp_pkg::PH_DIRDATA;
                            end else if (r_phase == lprp_pkg::PH_ARGLEN) begin
                                done_str = 1'b1;
                                ckind    = lprp_pkg::KIND_ARG;
                                n_argc   = r_argc + LENGTH_BITS'(1);
                                n_left   = r_left - LENGTH_BITS'(1);
                                n_phase  = (r_left != LENGTH_BITS'(1))
                                           ? lprp_pkg::PH_ARGLEN : lprp_pkg::PH_DIRLEN;
                            end else begin
                                done_str = 1'b1;
                                ckind    = lprp_pkg::KIND_DIR;
                                n_phase  = lprp_pkg::PH_TAIL;
                            end
                        end
                    end
                end
                lprp_pkg::PH_ARGDATA: begin
                    kind      = lprp_pkg::KIND_ARG;
                    n_content = r_content - LENGTH_BITS'(1);
                    if (r_content == LENGTH_BITS'(1)) begin
                        done_str = 1'b1;
                        ckind    = lprp_pkg::KIND_ARG;
                        n_argc   = r_argc + LENGTH_BITS'(1);
                        n_left   = r_left - LENGTH_BITS'(1);
                        n_phase  = (r_left != LENGTH_BITS'(1))
                                   ? lprp_pkg::PH_ARGLEN : lprp_pkg::PH_DIRLEN;
                    end
                end
                lprp_pkg::PH_DIRDATA: begin
                    kind      = lprp_pkg::KIND_DIR;
                    n_content = r_content - LENGTH_BITS'(1);
                    if (r_content == LENGTH_BITS'(1)) begin
                        done_str = 1'b1;
                        ckind    = lprp_pkg::KIND_DIR;
                        n_phase  = lprp_pkg::PH_TAIL;
                    end
                end
                default: begin
                    n_err = lprp_pkg::ST_TRAILING;
                end
            endcase
        end

        ph_after = n_phase;
        status   = n_err;
        if (i_req.end_of_payload && n_err == lprp_pkg::ST_OK) begin
            unique case (ph_after)
                lprp_pkg::PH_VERSION: status = lprp_pkg::ST_MISSING_VER;
                lprp_pkg::PH_COUNT:   status = lprp_pkg::ST_MISSING_COUNT;
                lprp_pkg::PH_ARGLEN,
                lprp_pkg::PH_ARGDATA: status = lprp_pkg::ST_TRUNC_ARG;
                lprp_pkg::PH_DIRLEN,
                lprp_pkg::PH_DIRDATA: status = lprp_pkg::ST_TRUNC_DIR;
                default:              status = lprp_pkg::ST_OK;
            endcase
        end

        o_res.byte_out        = i_req.has_byte ? i_req.data_byte : 8'd0;
        o_res.byte_kind       = kind;
        o_res.arg_number      = 32'(num);
        o_res.string_complete = done_str;
        o_res.complete_kind   = ckind;
        o_res.parse_done      = i_req.end_of_payload;
        o_res.parse_status    = status;
        o_res.arg_total       = 32'(n_total);

        // The last request of a payload returns the parser to its start.
        if (i_req.end_of_payload) begin
            n_phase   = lprp_pkg::PH_VERSION;
            n_wbc     = 2'd0;
            n_word    = '0;
            n_left    = '0;
            n_argc    = '0;
            n_total   = '0;
            n_content = '0;
            n_err     = lprp_pkg::ST_OK;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= lprp_pkg::PH_VERSION;
            r_wbc     <= 2'd0;
            r_word    <= '0;
            r_left    <= '0;
            r_argc    <= '0;
            r_total   <= '0;
            r_content <= '0;
            r_err     <= lprp_pkg::ST_OK;
        end else if (i_fire) begin
            r_phase   <= n_phase;
            r_wbc     <= n_wbc;
            r_word    <= n_word;
            r_left    <= n_left;
            r_argc    <= n_argc;
            r_total   <= n_total;
            r_content <= n_content;
            r_err     <= n_err;
        end
    end

    // Completed plus remaining arguments always add up to the decoded count.
    a_arg_balance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_argc + r_left) == r_total)
        else $error("argument counters out of balance");

    // A content phase is only entered with bytes still to come.
    a_content_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == lprp_pkg::PH_ARGDATA || r_phase == lprp_pkg::PH_DIRDATA)
        |-> r_content != '0)
        else $error("content phase with nothing remaining");

    // A latched error holds until the last request of the payload.
    a_err_latched: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_err != lprp_pkg::ST_OK && !(i_fire && i_req.end_of_payload))
        |=> r_err == $past(r_err))
        else $error("latched error changed before end of payload");

endmodule

// ===== rtl/length_prefixed_request_parser_core.sv =====
// ============================================================================
// length_prefixed_request_parser_core: streaming request payload parser
// Parses a version byte, a big-endian argument count, the length-prefixed
// argument strings and a length-prefixed directory string, one byte per
// request, and tags every byte with its role and the running status.
// ============================================================================
//
//  Channel   Signals                                        Direction
//  --------  ---------------------------------------------  ---------
//  request   i_in_valid, o_in_stall, i_has_byte,            in
//            i_data_byte, i_end_of_payload
//  result    o_out_valid, i_out_stall, o_byte_out, ...      out
//  config    i_cfg_we, i_cfg_data (expected version)        in
//
// One request is accepted per cycle while o_in_stall is low. It is held in the request
// register, then the step logic writes the result register, which drives the
// outputs. The step logic is combinational, so a new request is taken while
// the held one moves into the result register.
// Reset is synchronous and active low; the expected version returns to 1.
// A stalled result holds the result register, which holds the request
// register, and only then is the upstream side stalled.
//
module length_prefixed_request_parser_core #(
    parameter int LENGTH_BITS = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [7:0]  i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic        i_has_byte,
    input  logic [7:0]  i_data_byte,
    input  logic        i_end_of_payload,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [7:0]  o_byte_out,
    output logic [1:0]  o_byte_kind,
    output logic [31:0] o_arg_number,
    output logic        o_string_complete,
    output logic [1:0]  o_complete_kind,
    output logic        o_parse_done,
    output logic [2:0]  o_parse_status,
    output logic [31:0] o_arg_total
);

    logic [7:0]      r_exp_ver;
    logic            r_in_valid, n_in_valid;
    lprp_pkg::t_req  r_in;
    logic            r_out_valid, n_out_valid;
    lprp_pkg::t_res  r_out;
    lprp_pkg::t_res  step_res;

    logic out_adv;
    logic fire;
    logic in_acc;

    // The result register can take a new value when it is empty or being read.
    assign out_adv    = !r_out_valid || !i_out_stall;
    // The held request is processed in the cycle it moves into the result register.
    assign fire       = r_in_valid && out_adv;
    assign o_in_stall = r_in_valid && !out_adv;
    assign in_acc     = i_in_valid && !o_in_stall;

    always_comb begin
        n_in_valid = r_in_valid;
        if (in_acc) begin
            n_in_valid = 1'b1;
        end else if (fire) begin
            n_in_valid = 1'b0;
        end
        n_out_valid = r_out_valid;
        if (out_adv) begin
            n_out_valid = fire;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_exp_ver   <= lprp_pkg::OPEN_VERSION;
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_exp_ver <= i_cfg_data;
            end
            r_in_valid  <= n_in_valid;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_in.has_byte       <= i_has_byte;
            r_in.data_byte      <= i_data_byte;
            r_in.end_of_payload <= i_end_of_payload;
        end
        if (fire) begin
            r_out <= step_res;
        end
    end

    lprp_parse #(
        .LENGTH_BITS(LENGTH_BITS)
    ) u_parse (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_fire    (fire),
        .i_req     (r_in),
        .i_exp_ver (r_exp_ver),
        .o_res     (step_res)
    );

    assign o_out_valid       = r_out_valid;
    assign o_byte_out        = r_out.byte_out;
    assign o_byte_kind       = r_out.byte_kind;
    assign o_arg_number      = r_out.arg_number;
    assign o_string_complete = r_out.string_complete;
    assign o_complete_kind   = r_out.complete_kind;
    assign o_parse_done      = r_out.parse_done;
    assign o_parse_status    = r_out.parse_status;
    assign o_arg_total       = r_out.arg_total;

endmodule

// ===== tb/tb_top.sv =====
// ============================================================================
// tb_top: self-checking bench for the length-prefixed request parser
// Streams directed, well-formed, broken and noise request payloads through
// length_prefixed_request_parser_core. The sender works in random bursts and
// the receiver stalls on a changing pattern. A scoreboard predicts the tag,
// string completion and status of every request and compares each result
// field by field.
// ============================================================================
module tb_top;

    localparam int LEN_BITS     = 32;
    localparam int PREFIX_BYTES = (LEN_BITS + 7) / 8;
    // Random requests per expected-version setting; six settings are visited.
    localparam int PHASE_ITEMS  = 290;
    // Cycles with no handshake on either channel before the run is abandoned.
    // The longest legal quiet stretch is a sender gap, a drain pause or a
    // register write, all far shorter than this.
    localparam int IDLE_LIMIT   = 5000;
    // Margin that lets the pipeline settle once every result has come back.
    localparam int PIPE_SETTLE  = 6;

    // ------------------------------------------------------------------------
    // Scoreboard: keeps its own copy of the parse state and the expected
    // version, turns each accepted request into the tagged result the parser
    // must produce, and holds those results in order until they come out.
    // ------------------------------------------------------------------------
    class parse_scoreboard;
        logic [7:0]       want_version;
        lprp_pkg::t_phase cur_phase;
        logic [1:0]       prefix_count;
        logic [31:0]      prefix_accum;
        logic [31:0]      prefix_word;
        logic [31:0]      args_left;
        logic [31:0]      args_done;
        logic [31:0]      arg_count;
        logic [31:0]      bytes_left;
        logic [2:0]       latched_err;
        lprp_pkg::t_res   pending_tags[$];
        int unsigned      fail_count;

        function new();
            want_version = lprp_pkg::OPEN_VERSION;
            fail_count   = 0;
            clear_parse();
        endfunction

        function void clear_parse();
            cur_phase    = lprp_pkg::PH_VERSION;
            prefix_count = '0;
            prefix_accum = '0;
            prefix_word  = '0;
            args_left    = '0;
            args_done    = '0;
            arg_count    = '0;
            bytes_left   = '0;
            latched_err  = lprp_pkg::ST_OK;
        endfunction

        // Shifts one prefix byte in. The byte counter is two bits wide, so a
        // four-byte prefix completes when it wraps back to zero.
        function bit shift_prefix(logic [7:0] b);
            logic [63:0] mask;
            mask = (64'd1 << LEN_BITS) - 64'd1;
            prefix_accum = {prefix_accum[23:0], b};
            prefix_count = prefix_count + 2'd1;
            if (prefix_count == 2'(PREFIX_BYTES)) begin
                prefix_count = '0;
                prefix_word  = prefix_accum & mask[31:0];
                prefix_accum = '0;
                return 1'b1;
            end
            return 1'b0;
        endfunction

        function void finish_arg();
            args_done = args_done + 32'd1;
            args_left = args_left - 32'd1;
            if (args_left != 0) begin
                cur_phase = lprp_pkg::PH_ARGLEN;
            end else begin
                cur_phase = lprp_pkg::PH_DIRLEN;
            end
        endfunction

        function void tag_request(lprp_pkg::t_req rq);
            lprp_pkg::t_res r;
            r = '0;
            r.arg_number = args_done;
            if (rq.has_byte && latched_err == lprp_pkg::ST_OK) begin
                case (cur_phase)
                    lprp_pkg::PH_VERSION: begin
                        if (rq.data_byte != want_version) begin
                            latched_err = lprp_pkg::ST_BAD_VER;
                        end else begin
                            cur_phase    = lprp_pkg::PH_COUNT;
                            prefix_count = '0;
                            prefix_accum = '0;
                        end
                    end
                    lprp_pkg::PH_COUNT: begin
                        if (shift_prefix(rq.data_byte)) begin
                            arg_count    = prefix_word;
                            args_left    = prefix_word;
                            args_done    = '0;
                            r.arg_number = '0;
                            if (args_left != 0) begin
                                cur_phase = lprp_pkg::PH_ARGLEN;
                            end else begin
                                cur_phase = lprp_pkg::PH_DIRLEN;
                            end
                        end
                    end
                    lprp_pkg::PH_ARGLEN: begin
                        if (shift_prefix(rq.data_byte)) begin
                            bytes_left = prefix_word;
                            if (bytes_left == 0) begin
                                r.string_complete = 1'b1;
                                r.complete_kind   = lprp_pkg::KIND_ARG;
                                finish_arg();
                            end else begin
                                cur_phase = lprp_pkg::PH_ARGDATA;
                            end
                        end
                    end
                    lprp_pkg::PH_ARGDATA: begin
                        r.byte_kind = lprp_pkg::KIND_ARG;
                        bytes_left  = bytes_left - 32'd1;
                        if (bytes_left == 0) begin
                            r.string_complete = 1'b1;
                            r.complete_kind   = lprp_pkg::KIND_ARG;
                            finish_arg();
                        end
                    end
                    lprp_pkg::PH_DIRLEN: begin
                        if (shift_prefix(rq.data_byte)) begin
                            bytes_left = prefix_word;
                            if (bytes_left == 0) begin
                                r.string_complete = 1'b1;
                                r.complete_kind   = lprp_pkg::KIND_DIR;
                                cur_phase         = lprp_pkg::PH_TAIL;
                            end else begin
                                cur_phase = lprp_pkg::PH_DIRDATA;
                            end
                        end
                    end
                    lprp_pkg::PH_DIRDATA: begin
                        r.byte_kind = lprp_pkg::KIND_DIR;
                        bytes_left  = bytes_left - 32'd1;
                        if (bytes_left == 0) begin
                            r.string_complete = 1'b1;
                            r.complete_kind   = lprp_pkg::KIND_DIR;
                            cur_phase         = lprp_pkg::PH_TAIL;
                        end
                    end
                    default: latched_err = lprp_pkg::ST_TRAILING;
                endcase
            end

            // A latched error wins; otherwise the last request reports where
            // the payload stopped.
            r.parse_status = latched_err;
            if (rq.end_of_payload && latched_err == lprp_pkg::ST_OK) begin
                case (cur_phase)
                    lprp_pkg::PH_VERSION: r.parse_status = lprp_pkg::ST_MISSING_VER;
                    lprp_pkg::PH_COUNT:   r.parse_status = lprp_pkg::ST_MISSING_COUNT;
                    lprp_pkg::PH_ARGLEN,
                    lprp_pkg::PH_ARGDATA: r.parse_status = lprp_pkg::ST_TRUNC_ARG;
                    lprp_pkg::PH_DIRLEN,
                    lprp_pkg::PH_DIRDATA: r.parse_status = lprp_pkg::ST_TRUNC_DIR;
                    default:              r.parse_status = lprp_pkg::ST_OK;
                endcase
            end
            r.byte_out   = rq.has_byte ? rq.data_byte : 8'd0;
            r.parse_done = rq.end_of_payload;
            r.arg_total  = arg_count;
            pending_tags.insert(pending_tags.size(), r);
            if (rq.end_of_payload) begin
                clear_parse();
            end
        endfunction

        task report_mismatch(string msg);
            fail_count++;
            $display("ERROR: %s", msg);
        endtask

        task check_field(string name, logic [31:0] got, logic [31:0] want);
            if (got !== want) begin
                report_mismatch($sformatf("%s got 0x%0h, expected 0x%0h (%0d pending)",
                                          name, got, want, pending_tags.size()));
            end
        endtask

        task compare_tags(lprp_pkg::t_res got);
            lprp_pkg::t_res want;
            if (pending_tags.size() == 0) begin
                report_mismatch("result arrived with no request outstanding");
                return;
            end
            want = pending_tags.pop_front();
            check_field("byte_out",        32'(got.byte_out),        32'(want.byte_out));
            check_field("byte_kind",       32'(got.byte_kind),       32'(want.byte_kind));
            check_field("arg_number",      got.arg_number,           want.arg_number);
            check_field("string_complete", 32'(got.string_complete), 32'(want.string_complete));
            check_field("complete_kind",   32'(got.complete_kind),   32'(want.complete_kind));
            check_field("parse_done",      32'(got.parse_done),      32'(want.parse_done));
            check_field("parse_status",    32'(got.parse_status),    32'(want.parse_status));
            check_field("arg_total",       got.arg_total,            want.arg_total);
        endtask
    endclass

    typedef enum logic [1:0] {
        STALL_NONE,
        STALL_RANDOM,
        STALL_PERIODIC
    } t_stall_style;

    // ------------------------------------------------------------------------
    // Clock, reset and block ports. Every input starts at a known value.
    // ------------------------------------------------------------------------
    logic        i_clk            = 1'b0;
    logic        i_rst_n          = 1'b0;
    logic        i_cfg_we         = 1'b0;
    logic [7:0]  i_cfg_data       = 8'd0;
    logic        i_in_valid       = 1'b0;
    logic        o_in_stall;
    logic        i_has_byte       = 1'b0;
    logic [7:0]  i_data_byte      = 8'd0;
    logic        i_end_of_payload = 1'b0;
    logic        o_out_valid;
    logic        i_out_stall      = 1'b0;
    logic [7:0]  o_byte_out;
    logic [1:0]  o_byte_kind;
    logic [31:0] o_arg_number;
    logic        o_string_complete;
    logic [1:0]  o_complete_kind;
    logic        o_parse_done;
    logic [2:0]  o_parse_status;
    logic [31:0] o_arg_total;

    parse_scoreboard sb;

    logic [7:0]   payload_q[$];
    int           items_sent   = 0;
    int           burst_left   = 0;
    int           idle_cycles  = 0;
    int           stall_hold   = 0;
    logic [7:0]   stall_tick   = 8'd0;
    t_stall_style stall_style  = STALL_NONE;

    always #2 i_clk = ~i_clk;

    length_prefixed_request_parser_core #(
        .LENGTH_BITS (LEN_BITS)
    ) dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_data        (i_cfg_data),
        .i_in_valid        (i_in_valid),
        .o_in_stall        (o_in_stall),
        .i_has_byte        (i_has_byte),
        .i_data_byte       (i_data_byte),
        .i_end_of_payload  (i_end_of_payload),
        .o_out_valid       (o_out_valid),
        .i_out_stall       (i_out_stall),
        .o_byte_out        (o_byte_out),
        .o_byte_kind       (o_byte_kind),
        .o_arg_number      (o_arg_number),
        .o_string_complete (o_string_complete),
        .o_complete_kind   (o_complete_kind),
        .o_parse_done      (o_parse_done),
        .o_parse_status    (o_parse_status),
        .o_arg_total       (o_arg_total)
    );

    // ------------------------------------------------------------------------
    // Request sender. It is always entered at a falling edge. When a burst
    // runs out, valid drops for a random gap (possibly none) and a new burst
    // length is drawn; every so often a burst is long enough to run with no
    // gaps at all. The request is held until the rising edge at which the
    // parser does not stall, and only then is it handed to the scoreboard.
    // ------------------------------------------------------------------------
    task send_request(bit has, logic [7:0] b, bit eop);
        lprp_pkg::t_req rq;
        int             gap;
        if (burst_left == 0) begin
            if ($urandom_range(0, 7) == 0) begin
                burst_left = 300;
            end else begin
                burst_left = $urandom_range(1, 24);
            end
            gap = $urandom_range(0, 9);
            if (gap > 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
        end
        rq.has_byte       = has;
        rq.data_byte      = b;
        rq.end_of_payload = eop;
        i_in_valid       <= 1'b1;
        i_has_byte       <= has;
        i_data_byte      <= b;
        i_end_of_payload <= eop;
        do @(posedge i_clk); while (o_in_stall);
        sb.tag_request(rq);
        items_sent++;
        burst_left--;
        @(negedge i_clk);
    endtask

    // Stops sending and waits until every predicted result has come back,
    // then lets the two-stage pipeline settle.
    task wait_drained();
        i_in_valid <= 1'b0;
        while (sb.pending_tags.size() != 0) @(negedge i_clk);
        repeat (PIPE_SETTLE) @(negedge i_clk);
    endtask

    // The expected version may only change while the parser is empty.
    task write_version(logic [7:0] v);
        wait_drained();
        i_cfg_we   <= 1'b1;
        i_cfg_data <= v;
        @(negedge i_clk);
        i_cfg_we        <= 1'b0;
        sb.want_version  = v;
    endtask

    // Appends one byte to the payload being built.
    function void add_byte(logic [7:0] b);
        payload_q.insert(payload_q.size(), b);
    endfunction

    function void push_word(logic [31:0] w);
        for (int k = PREFIX_BYTES - 1; k >= 0; k--) begin
            add_byte(8'(w >> (8 * k)));
        end
    endfunction

    // A complete payload: version, count, the argument strings and the
    // directory string, with random lengths kept small.
    function void build_good_payload(int max_args, int max_len);
        int n_args;
        int len;
        payload_q.delete();
        add_byte(sb.want_version);
        n_args = $urandom_range(0, max_args);
        push_word(32'(n_args));
        repeat (n_args) begin
            len = $urandom_range(0, max_len);
            push_word(32'(len));
            repeat (len) add_byte(8'($urandom));
        end
        len = $urandom_range(0, max_len + 2);
        push_word(32'(len));
        repeat (len) add_byte(8'($urandom));
    endfunction

    // Sends the queued payload. Now and then a request with no byte and no
    // end mark slips in ahead of a byte. The end mark either rides on the last
    // byte or comes alone on a byte-less request.
    task send_payload(bit end_alone);
        for (int i = 0; i < payload_q.size(); i++) begin
            if ($urandom_range(0, 24) == 0) begin
                send_request(1'b0, 8'($urandom), 1'b0);
            end
            send_request(1'b1, payload_q[i], !end_alone && (i == payload_q.size() - 1));
        end
        if (end_alone) begin
            send_request(1'b0, 8'($urandom), 1'b1);
        end
    endtask

    // Mostly well-formed payloads with random content; the rest are cut
    // short, carry trailing bytes, a wrong version or oversized prefixes, or
    // are plain noise.
    task run_random_phase(int items);
        int goal;
        int pick;
        int cut;
        goal = items_sent + items;
        while (items_sent < goal) begin
            pick = $urandom_range(0, 99);
            if (pick < 65) begin
                build_good_payload(4, 6);
            end else if (pick < 85) begin
                build_good_payload(3, 5);
                case ($urandom_range(0, 3))
                    0: payload_q[0] = 8'($urandom);
                    1: begin
                        cut = $urandom_range(0, payload_q.size() - 1);
                        while (payload_q.size() > cut) void'(payload_q.pop_back());
                    end
                    2: repeat ($urandom_range(1, 3)) add_byte(8'($urandom));
                    default: begin
                        // Huge count or huge argument length, then the
                        // payload stops long before either is satisfied.
                        payload_q.delete();
                        add_byte(sb.want_version);
                        push_word($urandom_range(0, 1) ? $urandom() : 32'd1);
                        push_word($urandom());
                        repeat ($urandom_range(0, 12)) add_byte(8'($urandom));
                    end
                endcase
            end else begin
                payload_q.delete();
                repeat ($urandom_range(1, 10)) add_byte(8'($urandom));
                if ($urandom_range(0, 1)) begin
                    payload_q[0] = sb.want_version;
                end
            end
            send_payload(1'($urandom_range(0, 1)));
            // Occasionally hold off until the parser has fully drained.
            if ($urandom_range(0, 59) == 0) begin
                wait_drained();
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // Main sequence: reset, a directed set of payloads at the reset version,
    // then random payloads under six expected-version settings that include
    // both extremes.
    // ------------------------------------------------------------------------
    initial begin
        sb = new();
        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Empty payload: only an end mark, so the version is missing.
        payload_q.delete();
        send_payload(1'b1);
        // All-ones byte where the version belongs.
        payload_q.delete();
        add_byte(8'hFF);
        send_payload(1'b0);
        // Good version, then the payload ends inside the count.
        payload_q.delete();
        add_byte(lprp_pkg::OPEN_VERSION);
        add_byte(8'h00);
        send_payload(1'b0);
        // One empty argument, a one-byte directory and a trailing byte.
        payload_q.delete();
        add_byte(lprp_pkg::OPEN_VERSION);
        push_word(32'd1);
        push_word(32'd0);
        push_word(32'd1);
        add_byte(8'h00);
        add_byte(8'hFF);
        send_payload(1'b0);
        // Largest possible count, then nothing: truncated argument.
        payload_q.delete();
        add_byte(lprp_pkg::OPEN_VERSION);
        push_word(32'hFFFF_FFFF);
        send_payload(1'b0);

        for (int k = 0; k < 6; k++) begin
            case (k)
                0:       write_version(8'h00);
                1:       write_version(8'hFF);
                2:       write_version(8'hA5);
                3:       write_version(8'h5A);
                4:       write_version(8'($urandom));
                default: write_version(lprp_pkg::OPEN_VERSION);
            endcase
            run_random_phase(PHASE_ITEMS);
        end

        wait_drained();
        if (sb.fail_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

    // ------------------------------------------------------------------------
    // Receiver: switches between no stalls, random stalls and a fixed
    // three-in-eight stall pattern, each held for a random stretch.
    // ------------------------------------------------------------------------
    always @(negedge i_clk) begin
        if (stall_hold == 0) begin
            stall_style = t_stall_style'($urandom_range(0, 2));
            stall_hold  = $urandom_range(16, 160);
        end
        stall_hold = stall_hold - 1;
        stall_tick = stall_tick + 8'd1;
        case (stall_style)
            STALL_NONE:   i_out_stall <= 1'b0;
            STALL_RANDOM: i_out_stall <= ($urandom_range(0, 3) == 0);
            default:      i_out_stall <= (stall_tick[2:0] > 3'd4);
        endcase
    end

    // Every result taken at a rising edge goes to the scoreboard.
    always @(posedge i_clk) begin : result_monitor
        lprp_pkg::t_res seen;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            seen.byte_out        = o_byte_out;
            seen.byte_kind       = o_byte_kind;
            seen.arg_number      = o_arg_number;
            seen.string_complete = o_string_complete;
            seen.complete_kind   = o_complete_kind;
            seen.parse_done      = o_parse_done;
            seen.parse_status    = o_parse_status;
            seen.arg_total       = o_arg_total;
            sb.compare_tags(seen);
        end
    end

    // Watchdog: a lost result or a stuck stall shows up as a long stretch
    // with no handshake on either channel.
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

endmodule
